>>> design/sgfc_pkg.sv
package sgfc_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	localparam int BITS_PER_BYTE = 8;
	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;
	localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1000;

	typedef enum logic {
		CMD_STORE,
		CMD_DUMP
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
	} cmd_t;

endpackage

>>> design/sgfc_if.sv
interface sgfc_in_if;
	logic valid;
	logic ready;
	logic func;
	logic data_bit;

	modport source (output valid, output func, output data_bit, input ready);
	modport sink (input valid, input func, input data_bit, output ready);
endinterface

interface sgfc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

>>> design/sgfc_front.sv
module sgfc_front import sgfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	sgfc_in_if.sink     item,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_space
);

	logic [15:0] idle_limit_q;
	logic [7:0]  shift_q;
	logic [2:0]  bit_count_q;
	logic [15:0] idle_ticks_q;
	logic        running_q;

	logic        take;
	logic [7:0]  shift_next;
	logic        byte_done;
	logic [15:0] ticks_next;
	logic        timeout;

	// every accepted item may push one command, so only take one when there is space
	assign item.ready = cmd_space;
	assign take       = item.valid && item.ready;

	assign shift_next = {shift_q[6:0], item.data_bit};
	assign byte_done  = (bit_count_q == 3'(BITS_PER_BYTE - 1));
	assign ticks_next = idle_ticks_q + 16'd1;
	assign timeout    = running_q && (ticks_next == idle_limit_q);

	always_comb begin
		cmd_valid = 1'b0;
		cmd.op    = CMD_STORE;
		cmd.data  = shift_next;
		if (take) begin
			if (!item.func) begin
				cmd_valid = byte_done;
			end else begin
				cmd_valid = timeout;
				cmd.op    = CMD_DUMP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RESET;
		end else if (cfg_we) begin
			idle_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q      <= '0;
			bit_count_q  <= '0;
			idle_ticks_q <= '0;
			running_q    <= 1'b1;
		end else if (take) begin
			if (!item.func) begin
				idle_ticks_q <= '0;
				running_q    <= 1'b1;
				if (byte_done) begin
					shift_q     <= '0;
					bit_count_q <= '0;
				end else begin
					shift_q     <= shift_next;
					bit_count_q <= bit_count_q + 3'd1;
				end
			end else if (running_q) begin
				if (timeout) begin
					// frame ends: stop the timer and drop the partial byte
					running_q    <= 1'b0;
					idle_ticks_q <= '0;
					shift_q      <= '0;
					bit_count_q  <= '0;
				end else begin
					idle_ticks_q <= ticks_next;
				end
			end
		end
	end

endmodule

>>> design/sgfc_cmd_queue.sv
module sgfc_cmd_queue import sgfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic space,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign space     = (fill_q != 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_push   = push && space;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> design/sgfc_back.sv
module sgfc_back import sgfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  cmd_t     cmd,
	output logic     cmd_ready,
	sgfc_out_if.source result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_CR,
		ST_LF
	} state_t;

	localparam logic [CNT_W-1:0] DEPTH = CNT_W'(BUFFER_DEPTH);

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [7:0]       rd_data_q;
	logic [7:0]       mem [BUFFER_DEPTH];
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic out_free;
	logic out_load;
	logic store;

	assign cmd_ready       = (state_q == ST_IDLE);
	assign out_free        = !out_valid_q || result.ready;
	assign out_load        = out_free && (state_q inside {ST_EMIT, ST_CR, ST_LF});
	assign store           = cmd_valid && cmd_ready && (cmd.op == CMD_STORE) && (count_q < DEPTH);
	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.last     = out_last_q;

	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q[IDX_W-1:0]] <= cmd.data;
		end
		rd_data_q <= mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == CMD_STORE) begin
							// a full buffer drops the byte
							if (count_q < DEPTH) begin
								count_q <= count_q + 1'b1;
							end
						end else begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					// read data for idx_q lands in rd_data_q at this edge
					state_q <= (idx_q < count_q) ? ST_EMIT : ST_CR;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_byte_q  <= rd_data_q;
						out_last_q  <= 1'b0;
						idx_q       <= idx_q + 1'b1;
						state_q     <= ST_READ;
					end
				end
				ST_CR: begin
					if (out_free) begin
						out_byte_q  <= CHAR_CR;
						out_last_q  <= 1'b0;
						state_q     <= ST_LF;
					end
				end
				ST_LF: begin
					if (out_free) begin
						out_byte_q  <= CHAR_LF;
						out_last_q  <= 1'b1;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/spi_gap_framed_byte_capture.sv
// dump: a timeout tick's command passes through the command queue; the back end then
// reads each buffered byte into rd_data_q before loading it into the output register,
// then emits cr and lf; output back-pressure stalls each load
// throughput: one item per cycle while the two-entry command queue has room
// reset: asynchronous, active low; timer running, idle limit 1000, buffer empty
// the byte buffer is not cleared, a fill count marks its valid entries
module spi_gap_framed_byte_capture import sgfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	sgfc_in_if.sink     item,
	sgfc_out_if.source  result
);

	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_space;
	logic cmd_valid;
	cmd_t cmd_out;
	logic cmd_ready;

	sgfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd_valid (cmd_push),
		.cmd       (cmd_in),
		.cmd_space (cmd_space)
	);

	sgfc_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_cmd  (cmd_in),
		.space     (cmd_space),
		.pop_valid (cmd_valid),
		.pop_cmd   (cmd_out),
		.pop       (cmd_ready)
	);

	sgfc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_ready (cmd_ready),
		.result    (result)
	);

endmodule
